// ===== hw/rtl/ncps_pkg.sv =====
// Shared types, constants and codes for the neighbor cache parent selector.
`timescale 1ns / 1ps
package ncps_pkg;

  localparam int DEF_CACHE_ENTRIES = 8;
  localparam logic [6:0] SCORE_WORST = 7'd127;
  localparam logic [6:0] SCORE_SAT = 7'd126;
  localparam logic [3:0] PING_PHASE = 4'd3;
  localparam logic [2:0] AGE_PHASE = 3'd4;
  localparam logic [2:0] AGE_MOD = 3'd5;

  localparam logic [1:0] FUNC_HEARD = 2'd0;
  localparam logic [1:0] FUNC_SEND_DONE = 2'd1;
  localparam logic [1:0] FUNC_PING_RSP = 2'd2;
  localparam logic [1:0] FUNC_LOCAL_SEND = 2'd3;

  localparam logic [1:0] REG_LOCAL_ADDR = 2'd0;
  localparam logic [1:0] REG_MAX_HOPS = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_EVAL_PERIOD = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [15:0] sender_addr;
    logic [15:0] prior_addr;
    logic [6:0] hop_distance;
    logic [15:0] dest_addr;
  } req_t;

  typedef struct packed {
    logic parent_valid;
    logic [15:0] parent_addr;
    logic [4:0] send_distance;
    logic send_go;
    logic ping_request;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_HIT,
    ST_SCAN_REP,
    ST_INSERT,
    ST_CHOOSE,
    ST_SNAP,
    ST_AGE,
    ST_FLUSH,
    ST_RECHOOSE,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch request, do event count / send flags
    logic clr_idx;    // restart entry walk
    logic step_idx;   // advance entry walk
    logic lookup;     // compare one entry to the source
    logic hit_upd;    // apply update to found entry
    logic scan_rep;   // examine one entry for replacement
    logic insert;     // write replacement slot
    logic scan_min;   // examine one entry for parent choice
    logic take_min;   // commit chosen parent
    logic snap;       // capture result fields, ping, forward
    logic age;        // age one entry
    logic flush_all;  // drop one entry during cache clear
    logic clr_marks;  // clear all marks
    logic clr_count;  // clear event count
    logic out_load;   // present result
  } cmd_t;

  typedef struct packed {
    logic last_idx;
    logic found;
    logic parent_present;
    logic do_eval;
    logic age_phase;
    logic rechoose;
    logic flush_req;
    logic [1:0] func;
  } sts_t;

endpackage

// ===== hw/rtl/neighbor_cache_parent_select.sv =====
// Top level of the neighbor cache parent selector.
// Usage: present a request on in_req with in_valid; it is taken at an edge
// where in_valid is high and in_stall is low. Each request (packet heard, send
// done, ping response, local send) yields exactly one result on out_rsp,
// valid while out_valid is high, taken when out_stall is low.
// Ping response and local send do not walk the cache. A packet heard walks it
// to look up the sender, to pick a replacement slot on a miss and to choose a
// parent when none is present; at evaluation points it also walks it to age
// entries or clear the cache and to rechoose the parent, and send done takes
// only those evaluation walks. The walks visit one cache entry per cycle, so
// the entry count sets the rate; one request is in work at a time and the next
// one is taken after the result is presented.
// While a result waits under out_stall the block finishes the next request
// and holds it until the output register frees.
// Reset (rst_n low, synchronous) empties the cache, drops the parent, clears
// the event count and send busy flag, and loads register defaults.
// Write registers through cfg_we/cfg_index/cfg_data only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
module neighbor_cache_parent_select #(
  parameter int CACHE_ENTRIES = ncps_pkg::DEF_CACHE_ENTRIES
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  ncps_pkg::req_t in_req,
  output logic out_valid,
  input  logic out_stall,
  output ncps_pkg::rsp_t out_rsp,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import ncps_pkg::*;

  logic [15:0] local_addr_r;
  logic [3:0] hop_limit_r;
  logic [6:0] timeout_r;
  logic [5:0] period_r;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= 16'd0;
      hop_limit_r <= 4'd8;
      timeout_r <= 7'd80;
      period_r <= 6'd40;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_ADDR: local_addr_r <= cfg_data;
        REG_MAX_HOPS: hop_limit_r <= cfg_data[3:0];
        REG_TIMEOUT: timeout_r <= cfg_data[6:0];
        REG_EVAL_PERIOD: period_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  ncps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  ncps_dp #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .local_addr(local_addr_r),
    .hop_limit(hop_limit_r), .timeout_level(timeout_r), .eval_period(period_r),
    .cmd(cmd), .sts(sts), .out_rsp(out_rsp)
  );
endmodule

// ===== hw/rtl/ncps_ctrl.sv =====
// Controller state machine sequencing the cache walks for one request.
`timescale 1ns / 1ps
module ncps_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  ncps_pkg::sts_t sts,
  output ncps_pkg::cmd_t cmd
);
  import ncps_pkg::*;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) begin
        state_nxt = (sts.func == FUNC_HEARD) ? ST_LOOKUP : ST_SNAP;
      end
      ST_LOOKUP: begin
        if (sts.found) state_nxt = ST_HIT;
        else if (sts.last_idx) state_nxt = ST_SCAN_REP;
      end
      ST_HIT: state_nxt = ST_CHOOSE;
      ST_SCAN_REP: if (sts.last_idx) state_nxt = ST_INSERT;
      ST_INSERT: state_nxt = ST_CHOOSE;
      ST_CHOOSE: if (sts.parent_present || sts.last_idx) state_nxt = ST_SNAP;
      ST_SNAP: begin
        if (!sts.do_eval) state_nxt = ST_DONE;
        else if (sts.age_phase) state_nxt = ST_AGE;
        else if (sts.rechoose) state_nxt = ST_RECHOOSE;
        else state_nxt = ST_DONE;
      end
      ST_AGE: begin
        if (sts.flush_req) state_nxt = ST_FLUSH;
        else if (sts.last_idx) state_nxt = sts.rechoose ? ST_RECHOOSE : ST_DONE;
      end
      ST_FLUSH: if (sts.last_idx) state_nxt = sts.rechoose ? ST_RECHOOSE : ST_DONE;
      ST_RECHOOSE: if (sts.last_idx) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        cmd.clr_idx = 1'b1;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (!sts.found) cmd.step_idx = 1'b1;
        if (sts.last_idx && !sts.found) cmd.clr_idx = 1'b1;
      end
      ST_HIT: begin
        cmd.hit_upd = 1'b1;
        cmd.clr_idx = 1'b1;
      end
      ST_SCAN_REP: begin
        cmd.scan_rep = 1'b1;
        cmd.step_idx = 1'b1;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        cmd.clr_idx = 1'b1;
      end
      ST_CHOOSE: begin
        if (!sts.parent_present) begin
          cmd.scan_min = 1'b1;
          cmd.step_idx = 1'b1;
          cmd.take_min = sts.last_idx;
        end
      end
      ST_SNAP: begin
        cmd.snap = 1'b1;
        cmd.clr_idx = 1'b1;
      end
      ST_AGE: begin
        if (sts.flush_req) begin
          cmd.clr_idx = 1'b1;
        end else begin
          cmd.age = 1'b1;
          cmd.step_idx = 1'b1;
          if (sts.last_idx) begin
            cmd.clr_marks = 1'b1;
            cmd.clr_idx = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        cmd.flush_all = 1'b1;
        cmd.step_idx = 1'b1;
        if (sts.last_idx) begin
          cmd.clr_marks = 1'b1;
          cmd.clr_idx = 1'b1;
        end
      end
      ST_RECHOOSE: begin
        cmd.scan_min = 1'b1;
        cmd.step_idx = 1'b1;
        if (sts.last_idx) begin
          cmd.take_min = 1'b1;
          cmd.clr_count = 1'b1;
        end
      end
      ST_DONE: if (!out_valid_r || !out_stall) begin
        cmd.out_load = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("result lost under stall");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == ST_IDLE))
    else $error("load outside idle");
endmodule

// ===== hw/rtl/ncps_dp.sv =====
// Datapath: neighbor table, marks, counters and result registers.
`timescale 1ns / 1ps
module ncps_dp #(
  parameter int CACHE_ENTRIES = ncps_pkg::DEF_CACHE_ENTRIES
) (
  input  logic clk,
  input  logic rst_n,
  input  ncps_pkg::req_t in_req,
  input  logic [15:0] local_addr,
  input  logic [3:0] hop_limit,
  input  logic [6:0] timeout_level,
  input  logic [5:0] eval_period,
  input  ncps_pkg::cmd_t cmd,
  output ncps_pkg::sts_t sts,
  output ncps_pkg::rsp_t out_rsp
);
  import ncps_pkg::*;

  localparam int IW = $clog2(CACHE_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(CACHE_ENTRIES - 1);

  logic [CACHE_ENTRIES-1:0] used_r, heard_r, echo_r;
  logic [15:0] addr_r [CACHE_ENTRIES];
  logic [4:0] hops_r [CACHE_ENTRIES];
  logic [6:0] score_r [CACHE_ENTRIES];
  logic [IW-1:0] pslot_r, idx_r, sel_r;
  logic ppres_r, busy_r;
  logic [5:0] count_r;
  logic [7:0] best_r;
  logic best_ok_r;
  req_t req_r;
  rsp_t rsp_r, res_r;

  logic [4:0] drop_hops;
  logic is_par, mark_echo, hit_drop;
  logic [6:0] pkt_hops;
  logic signed [8:0] hsum, asum;
  logic [6:0] hsat, asat;
  logic [1:0] e_bit, h_bit;

  function automatic logic [6:0] sat(input logic signed [8:0] v);
    if (v < 0) return 7'd0;
    else if (v > $signed({2'b00, SCORE_SAT})) return SCORE_WORST;
    else return v[6:0];
  endfunction

  // Aging phase: count equal to AGE_PHASE modulo AGE_MOD
  function automatic logic age_hit(input logic [5:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = int'(AGE_PHASE); k < 64; k += int'(AGE_MOD)) begin
      if (c == 6'(k)) hit = 1'b1;
    end
    return hit;
  endfunction

  assign drop_hops = {1'b0, hop_limit} + 5'd1;
  assign is_par = ppres_r && (pslot_r == idx_r);
  assign pkt_hops = req_r.hop_distance;
  assign mark_echo = (req_r.prior_addr == local_addr);
  assign hit_drop = (({5'd0, hops_r[idx_r]} < {3'd0, pkt_hops}) && is_par) ||
                    (pkt_hops > {3'd0, hop_limit});
  assign hsum = $signed({2'b00, score_r[idx_r]}) + $signed({2'b00, pkt_hops}) -
                $signed({4'b0, hops_r[idx_r]});
  assign hsat = sat(hsum);
  assign e_bit = {1'b0, echo_r[idx_r]};
  assign h_bit = {1'b0, heard_r[idx_r]};
  assign asum = $signed({2'b00, score_r[idx_r]}) + 9'sd3 -
                $signed({6'd0, e_bit, 1'b0}) - $signed({7'd0, h_bit});
  assign asat = sat(asum);

  always_comb begin
    sts.last_idx = (idx_r == LAST);
    sts.found = used_r[idx_r] && (addr_r[idx_r] == req_r.sender_addr);
    sts.parent_present = ppres_r;
    sts.do_eval = (req_r.func == FUNC_HEARD) || (req_r.func == FUNC_SEND_DONE);
    sts.age_phase = age_hit(count_r);
    sts.rechoose = (count_r == eval_period);
    sts.flush_req = used_r[idx_r] && (score_r[idx_r] > timeout_level) && is_par;
    sts.func = in_req.func;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      heard_r <= '0;
      echo_r <= '0;
      pslot_r <= '0;
      ppres_r <= 1'b0;
      busy_r <= 1'b0;
      count_r <= '0;
      idx_r <= '0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        hops_r[i] <= 5'd9;
        score_r[i] <= SCORE_WORST;
      end
    end else begin
      if (cmd.clr_idx) idx_r <= '0;
      else if (cmd.step_idx) idx_r <= idx_r + IW'(1);

      if (cmd.load) begin
        req_r <= in_req;
        best_r <= {1'b0, SCORE_WORST};
        best_ok_r <= 1'b0;
        sel_r <= '0;
        res_r <= '0;
        case (in_req.func)
          FUNC_HEARD: count_r <= count_r + 6'd1;
          FUNC_SEND_DONE: begin
            count_r <= count_r + 6'd1;
            busy_r <= 1'b0;
          end
          FUNC_PING_RSP: if (ppres_r && addr_r[pslot_r] == in_req.sender_addr) begin
            echo_r[pslot_r] <= 1'b1;
            heard_r[pslot_r] <= 1'b1;
          end
          FUNC_LOCAL_SEND: if (ppres_r && !busy_r) begin
            busy_r <= 1'b1;
            res_r.send_go <= 1'b1;
          end
          default: ;
        endcase
      end

      if (cmd.lookup && !sts.found) begin
        // on a miss at the first entry, clear best_r for the replacement scan, which reuses it as worst+1
        if (idx_r == '0) begin
          best_r <= '0;
        end
      end

      if (cmd.hit_upd) begin
        if (hit_drop) begin
          used_r[idx_r] <= 1'b0;
          hops_r[idx_r] <= drop_hops;
          score_r[idx_r] <= SCORE_WORST;
          heard_r[idx_r] <= 1'b0;
          echo_r[idx_r] <= 1'b0;
          if (is_par) ppres_r <= 1'b0;
        end else begin
          hops_r[idx_r] <= pkt_hops[4:0];
          score_r[idx_r] <= hsat;
          if (mark_echo) echo_r[idx_r] <= 1'b1;
          else heard_r[idx_r] <= 1'b1;
        end
        best_r <= {1'b0, SCORE_WORST};
      end

      if (cmd.scan_rep) begin
        if (!is_par && ({1'b0, score_r[idx_r]} + 8'd1 > best_r)) begin
          best_r <= {1'b0, score_r[idx_r]} + 8'd1;
          sel_r <= idx_r;
        end
        if (idx_r == '0 && is_par) best_r <= '0;
      end

      if (cmd.insert) begin
        best_r <= {1'b0, SCORE_WORST};
        if (pkt_hops <= {3'd0, hop_limit}) begin
          used_r[sel_r] <= 1'b1;
          addr_r[sel_r] <= req_r.sender_addr;
          hops_r[sel_r] <= pkt_hops[4:0];
          score_r[sel_r] <= pkt_hops;
          if (mark_echo) echo_r[sel_r] <= 1'b1;
          else heard_r[sel_r] <= 1'b1;
        end
      end

      if (cmd.scan_min) begin
        if (used_r[idx_r] && ({1'b0, score_r[idx_r]} < best_r)) begin
          best_r <= {1'b0, score_r[idx_r]};
          sel_r <= idx_r;
          best_ok_r <= 1'b1;
        end
      end
      if (cmd.take_min) begin
        if (best_ok_r || (used_r[idx_r] && ({1'b0, score_r[idx_r]} < best_r))) begin
          ppres_r <= 1'b1;
          pslot_r <= (used_r[idx_r] && ({1'b0, score_r[idx_r]} < best_r)) ? idx_r : sel_r;
        end
        best_ok_r <= 1'b0;
        best_r <= {1'b0, SCORE_WORST};
      end
      if (cmd.clr_count) count_r <= '0;

      if (cmd.snap) begin
        best_r <= {1'b0, SCORE_WORST};
        best_ok_r <= 1'b0;
        res_r.parent_valid <= ppres_r;
        res_r.parent_addr <= ppres_r ? addr_r[pslot_r] : 16'd0;
        res_r.send_distance <= ppres_r ? hops_r[pslot_r] + 5'd1 : 5'd0;
        res_r.ping_request <= sts.do_eval && (count_r[3:0] == PING_PHASE) && ppres_r;
        if (req_r.func == FUNC_HEARD && ppres_r && req_r.dest_addr == local_addr &&
            !busy_r) begin
          busy_r <= 1'b1;
          res_r.send_go <= 1'b1;
        end
      end

      if (cmd.age && used_r[idx_r]) begin
        if (score_r[idx_r] > timeout_level) begin
          used_r[idx_r] <= 1'b0;
          hops_r[idx_r] <= drop_hops;
          score_r[idx_r] <= SCORE_WORST;
        end else begin
          score_r[idx_r] <= asat;
        end
      end
      if (cmd.flush_all) begin
        used_r[idx_r] <= 1'b0;
        hops_r[idx_r] <= drop_hops;
        score_r[idx_r] <= SCORE_WORST;
        ppres_r <= 1'b0;
      end
      if (cmd.clr_marks) begin
        heard_r <= '0;
        echo_r <= '0;
      end
      if (cmd.out_load) rsp_r <= res_r;
    end
  end

  assign out_rsp = rsp_r;

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_min |=> (!ppres_r || used_r[pslot_r]))
    else $error("parent slot not in use");
  a_busy_go: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.snap && res_r.send_go) |-> (req_r.func == FUNC_LOCAL_SEND))
    else $error("double send");
  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.flush_all && sts.last_idx) |=> !ppres_r)
    else $error("parent survives flush");
endmodule
